// ===== hw/rtl/mllm_pkg.sv =====
package mllm_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_LINKED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LINKED     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_LIST   = 2'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic latch;    // capture a new command beat
    logic clr;      // one step of the post-reset clearing sweep
    logic lookup;   // read membership and links of the node
    logic unlink;   // splice the node out of its current list
    logic read_ht;  // read head and tail of the affected list
    logic link1;    // first write step of a link
    logic link2;    // second write step of a link
    logic emit;     // register the result beat
  } mllm_ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             node_bad;
    logic             tl_bad;
    logic             linked;
    logic             clr_last;
  } mllm_stat_t;

endpackage

// ===== hw/rtl/mllm_ctrl.sv =====
module mllm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  mllm_pkg::mllm_stat_t   stat,
  output mllm_pkg::mllm_ctl_t    ctl
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_LOOKUP = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_RDHT   = 3'd4;
  localparam logic [2:0] S_HT     = 3'd5;
  localparam logic [2:0] S_LINK2  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       link_path;

  // insert of a free node, or any move, ends in a link
  assign link_path = (stat.cmd == mllm_pkg::CMD_MOVE) ||
                     ((stat.cmd == mllm_pkg::CMD_INSERT) && !stat.linked);

  // next state and datapath commands
  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        if (stat.node_bad) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.lookup = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (stat.cmd) inside
          mllm_pkg::CMD_INSERT, mllm_pkg::CMD_MOVE: begin
            if (stat.tl_bad) begin
              ctl.emit   = 1'b1;
              state_next = S_IDLE;
            end else begin
              ctl.unlink = stat.linked && (stat.cmd == mllm_pkg::CMD_MOVE);
              state_next = S_RDHT;
            end
          end
          mllm_pkg::CMD_REMOVE: begin
            if (!stat.linked) begin
              ctl.emit   = 1'b1;
              state_next = S_IDLE;
            end else begin
              ctl.unlink = 1'b1;
              state_next = S_RDHT;
            end
          end
          mllm_pkg::CMD_PEEK: begin
            if (stat.linked) begin
              state_next = S_RDHT;
            end else begin
              ctl.emit   = 1'b1;
              state_next = S_IDLE;
            end
          end
        endcase
      end
      S_RDHT: begin
        ctl.read_ht = 1'b1;
        state_next  = S_HT;
      end
      S_HT: begin
        if (link_path) begin
          ctl.link1  = 1'b1;
          state_next = S_LINK2;
        end else begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_LINK2: begin
        ctl.link2  = 1'b1;
        ctl.emit   = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register; reset starts the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== hw/rtl/mllm_dp.sv =====
module mllm_dp #(
  parameter int NUM_NODES = 4096,
  parameter int NUM_LISTS = 1024,
  localparam int NW   = $clog2(NUM_NODES),
  localparam int NLW  = $clog2(NUM_NODES + 1),
  localparam int LW   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1,
  localparam int LAW  = $clog2(NUM_LISTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mllm_pkg::mllm_ctl_t           ctl,
  output mllm_pkg::mllm_stat_t          stat,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic [mllm_pkg::CMD_W-1:0]    command,
  input  logic [NW-1:0]                 node,
  input  logic [LW-1:0]                 target_list,
  input  logic                          at_tail,
  output logic                          done,
  output logic [mllm_pkg::STATUS_W-1:0] status,
  output logic [LAW-1:0]                node_list_after,
  output logic [NLW-1:0]                list_head,
  output logic [NLW-1:0]                list_tail
);

  localparam int MAXD = (NUM_NODES > NUM_LISTS) ? NUM_NODES : NUM_LISTS;
  localparam int CW   = $clog2(MAXD);

  localparam logic [NLW-1:0] NO_NODE = NLW'(NUM_NODES);
  localparam logic [LAW-1:0] NO_LIST = LAW'(NUM_LISTS);

  // link and pointer stores
  logic [NLW-1:0] next_mem [NUM_NODES];
  logic [NLW-1:0] prev_mem [NUM_NODES];
  logic [LAW-1:0] memb_mem [NUM_NODES];
  logic [NLW-1:0] head_mem [NUM_LISTS];
  logic [NLW-1:0] tail_mem [NUM_LISTS];

  // command context
  logic                       force_tail;
  logic [mllm_pkg::CMD_W-1:0] cmd_q;
  logic [NW-1:0]              node_q;
  logic [LW-1:0]              tl_q;
  logic                       tail_q;
  logic [CW-1:0]              clr_idx;

  // registered read data
  logic [LAW-1:0] cur_q;
  logic [NLW-1:0] p_q;
  logic [NLW-1:0] x_q;
  logic [NLW-1:0] h_q;
  logic [NLW-1:0] t_q;

  logic           clr_last;
  logic           clr_nodes;
  logic           clr_lists;
  logic           node_bad;
  logic           tl_bad;
  logic           linked;
  logic           p_ok;
  logic           x_ok;
  logic           h_ok;
  logic           t_ok;
  logic [NLW-1:0] pv;
  logic [NLW-1:0] xv;
  logic [NLW-1:0] hv;
  logic [NLW-1:0] tv;
  logic [NLW-1:0] node_n;
  logic [LAW-1:0] tl_l;
  logic [LW-1:0]  cur_idx;
  logic [LW-1:0]  ht_ra;

  logic           next_we;
  logic [NW-1:0]  next_wa;
  logic [NLW-1:0] next_wd;
  logic           prev_we;
  logic [NW-1:0]  prev_wa;
  logic [NLW-1:0] prev_wd;
  logic           memb_we;
  logic [NW-1:0]  memb_wa;
  logic [LAW-1:0] memb_wd;
  logic           head_we;
  logic [LW-1:0]  head_wa;
  logic [NLW-1:0] head_wd;
  logic           tail_we;
  logic [LW-1:0]  tail_wa;
  logic [NLW-1:0] tail_wd;

  logic [mllm_pkg::STATUS_W-1:0] res_status;
  logic [LAW-1:0]                res_list;
  logic [NLW-1:0]                res_head;
  logic [NLW-1:0]                res_tail;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      force_tail <= 1'b0;
    end else if (cfg_we) begin
      force_tail <= cfg_wdata;
    end
  end

  // capture the command beat
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q  <= command;
      node_q <= node;
      tl_q   <= target_list;
      tail_q <= at_tail | force_tail;
    end
  end

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (ctl.clr && !clr_last) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  assign clr_last  = (clr_idx == CW'(MAXD - 1));
  assign clr_nodes = ({1'b0, clr_idx} < (CW + 1)'(NUM_NODES));
  assign clr_lists = ({1'b0, clr_idx} < (CW + 1)'(NUM_LISTS));

  // decode of the context
  assign node_bad = ({1'b0, node_q} >= (NW + 1)'(NUM_NODES));
  assign tl_bad   = ({1'b0, tl_q} >= (LW + 1)'(NUM_LISTS));
  assign linked   = (cur_q < NO_LIST);
  assign p_ok     = (p_q < NO_NODE);
  assign x_ok     = (x_q < NO_NODE);
  assign h_ok     = (h_q < NO_NODE);
  assign t_ok     = (t_q < NO_NODE);
  assign pv       = p_ok ? p_q : NO_NODE;
  assign xv       = x_ok ? x_q : NO_NODE;
  assign hv       = h_ok ? h_q : NO_NODE;
  assign tv       = t_ok ? t_q : NO_NODE;
  assign node_n   = NLW'(node_q);
  assign tl_l     = LAW'(tl_q);
  assign cur_idx  = cur_q[LW-1:0];

  // remove and peek look at the node's own list, the rest at the target
  assign ht_ra = ((cmd_q == mllm_pkg::CMD_REMOVE) || (cmd_q == mllm_pkg::CMD_PEEK)) ?
                 cur_idx : tl_q;

  assign stat.cmd      = cmd_q;
  assign stat.node_bad = node_bad;
  assign stat.tl_bad   = tl_bad;
  assign stat.linked   = linked;
  assign stat.clr_last = clr_last;

  // next link writes
  always_comb begin
    next_we = 1'b0;
    next_wa = node_q;
    next_wd = NO_NODE;
    if (ctl.unlink && p_ok) begin
      next_we = 1'b1;
      next_wa = p_q[NW-1:0];
      next_wd = xv;
    end else if (ctl.link1 && tail_q && t_ok) begin
      next_we = 1'b1;
      next_wa = t_q[NW-1:0];
      next_wd = node_n;
    end else if (ctl.link1 && !tail_q) begin
      next_we = 1'b1;
      next_wd = hv;
    end else if (ctl.link2 && tail_q) begin
      next_we = 1'b1;
    end
  end

  // prev link writes
  always_comb begin
    prev_we = 1'b0;
    prev_wa = node_q;
    prev_wd = NO_NODE;
    if (ctl.unlink && x_ok) begin
      prev_we = 1'b1;
      prev_wa = x_q[NW-1:0];
      prev_wd = pv;
    end else if (ctl.link1 && tail_q) begin
      prev_we = 1'b1;
      prev_wd = tv;
    end else if (ctl.link1 && !tail_q && h_ok) begin
      prev_we = 1'b1;
      prev_wa = h_q[NW-1:0];
      prev_wd = node_n;
    end else if (ctl.link2 && !tail_q) begin
      prev_we = 1'b1;
    end
  end

  // membership writes
  always_comb begin
    memb_we = 1'b0;
    memb_wa = node_q;
    memb_wd = NO_LIST;
    if (ctl.clr) begin
      memb_we = clr_nodes;
      memb_wa = clr_idx[NW-1:0];
    end else if (ctl.unlink) begin
      memb_we = 1'b1;
    end else if (ctl.link1) begin
      memb_we = 1'b1;
      memb_wd = tl_l;
    end
  end

  // head pointer writes
  always_comb begin
    head_we = 1'b0;
    head_wa = tl_q;
    head_wd = node_n;
    if (ctl.clr) begin
      head_we = clr_lists;
      head_wa = clr_idx[LW-1:0];
      head_wd = NO_NODE;
    end else if (ctl.unlink && !p_ok) begin
      head_we = 1'b1;
      head_wa = cur_idx;
      head_wd = xv;
    end else if (ctl.link1 && (!tail_q || !t_ok)) begin
      head_we = 1'b1;
    end
  end

  // tail pointer writes
  always_comb begin
    tail_we = 1'b0;
    tail_wa = tl_q;
    tail_wd = node_n;
    if (ctl.clr) begin
      tail_we = clr_lists;
      tail_wa = clr_idx[LW-1:0];
      tail_wd = NO_NODE;
    end else if (ctl.unlink && !x_ok) begin
      tail_we = 1'b1;
      tail_wa = cur_idx;
      tail_wd = pv;
    end else if (ctl.link1 && (tail_q || !h_ok)) begin
      tail_we = 1'b1;
    end
  end

  // node stores: one write and one registered read each
  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_wa] <= next_wd;
    if (ctl.lookup) x_q <= next_mem[node_q];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_wa] <= prev_wd;
    if (ctl.lookup) p_q <= prev_mem[node_q];
  end

  always_ff @(posedge clk) begin
    if (memb_we) memb_mem[memb_wa] <= memb_wd;
    if (ctl.lookup) cur_q <= memb_mem[node_q];
  end

  // list stores
  always_ff @(posedge clk) begin
    if (head_we) head_mem[head_wa] <= head_wd;
    if (ctl.read_ht) h_q <= head_mem[ht_ra];
  end

  always_ff @(posedge clk) begin
    if (tail_we) tail_mem[tail_wa] <= tail_wd;
    if (ctl.read_ht) t_q <= tail_mem[ht_ra];
  end

  // result fields from the context and the pre-link head/tail
  always_comb begin
    res_status = mllm_pkg::ST_DONE;
    res_list   = NO_LIST;
    res_head   = NO_NODE;
    res_tail   = NO_NODE;
    if (node_bad) begin
      res_status = mllm_pkg::ST_NOT_LINKED;
    end else begin
      unique case (cmd_q) inside
        mllm_pkg::CMD_INSERT, mllm_pkg::CMD_MOVE: begin
          if (tl_bad) begin
            res_status = mllm_pkg::ST_BAD_LIST;
            res_list   = cur_q;
          end else if ((cmd_q == mllm_pkg::CMD_INSERT) && linked) begin
            res_status = mllm_pkg::ST_LINKED;
            res_list   = cur_q;
            res_head   = h_q;
            res_tail   = t_q;
          end else if (tail_q) begin
            res_list = tl_l;
            res_head = t_ok ? h_q : node_n;
            res_tail = node_n;
          end else begin
            res_list = tl_l;
            res_head = node_n;
            res_tail = h_ok ? t_q : node_n;
          end
        end
        mllm_pkg::CMD_REMOVE: begin
          if (!linked) begin
            res_status = mllm_pkg::ST_NOT_LINKED;
          end else begin
            res_head = h_q;
            res_tail = t_q;
          end
        end
        mllm_pkg::CMD_PEEK: begin
          res_list = cur_q;
          if (linked) begin
            res_head = h_q;
            res_tail = t_q;
          end
        end
      endcase
    end
  end

  // result beat strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.emit;
    end
  end

  // result beat payload
  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status          <= res_status;
      node_list_after <= res_list;
      list_head       <= res_head;
      list_tail       <= res_tail;
    end
  end

endmodule

// ===== hw/rtl/multi_list_link_manager.sv =====
// Doubly linked list manager: NUM_NODES nodes threaded into NUM_LISTS lists.
// After reset, busy stays high while membership, heads and tails are swept to
// their empty values; configuration writes are taken during that time. A
// command is accepted when start is high and busy is low. Its result comes back
// as a one-cycle beat on done, in the same cycle that busy drops, and must be
// taken then: there is no way to hold it off. A node out of range is answered
// at the lookup step, a bad list or an unlinked remove or peek at the decide
// step, a remove, a peek or a rejected insert after the head/tail read, and an
// insert or a move after both link writes. The steps are set by the link
// stores, with one write port each: the lookup read, the unlink writes, the
// head/tail read and the two writes into the next/prev stores are each a step.
module multi_list_link_manager #(
  parameter int NUM_NODES = 4096,
  parameter int NUM_LISTS = 1024,
  localparam int NW   = $clog2(NUM_NODES),
  localparam int NLW  = $clog2(NUM_NODES + 1),
  localparam int LW   = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1,
  localparam int LAW  = $clog2(NUM_LISTS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          start,
  output logic                          busy,
  input  logic [mllm_pkg::CMD_W-1:0]    command,
  input  logic [NW-1:0]                 node,
  input  logic [LW-1:0]                 target_list,
  input  logic                          at_tail,
  output logic                          done,
  output logic [mllm_pkg::STATUS_W-1:0] status,
  output logic [LAW-1:0]                node_list_after,
  output logic [NLW-1:0]                list_head,
  output logic [NLW-1:0]                list_tail
);

  mllm_pkg::mllm_ctl_t  ctl;
  mllm_pkg::mllm_stat_t stat;

  // sequencer
  mllm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  // link stores and result path
  mllm_dp #(
    .NUM_NODES (NUM_NODES),
    .NUM_LISTS (NUM_LISTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .command         (command),
    .node            (node),
    .target_list     (target_list),
    .at_tail         (at_tail),
    .done            (done),
    .status          (status),
    .node_list_after (node_list_after),
    .list_head       (list_head),
    .list_tail       (list_tail)
  );

endmodule
